@@ design/bcb_pkg.sv @@
// Shared types and constants for the bipartite check block.
package bcb_pkg;

   // Field widths fixed by the request and result formats
   localparam int NODE_FIELD_W = 10;
   localparam int NODE_COUNT_W = 11;
   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_RANGE    = 2'd2;
   localparam logic [1:0] ERR_ORDER    = 2'd3;

   // Node colors
   localparam logic [1:0] COLOR_NONE = 2'd0;
   localparam logic [1:0] COLOR_RED  = 2'd1;
   localparam logic [1:0] COLOR_BLUE = 2'd2;

   typedef struct packed {
      logic [NODE_FIELD_W-1:0] source_node;
      logic [NODE_FIELD_W-1:0] neighbor_node;
      logic                    edge_valid;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic       is_bipartite;
      logic [1:0] error_code;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_POP,
      S_ROW_RD,
      S_ROW_CHK,
      S_EDGE_RD,
      S_COLOR_RD,
      S_COLOR_CHK,
      S_RESULT
   } state_type;

   typedef enum logic [3:0] {
      OP_CLEAR,
      OP_IDLE,
      OP_CHECK,
      OP_SCAN_RD,
      OP_SCAN_CHK,
      OP_POP,
      OP_ROW_RD,
      OP_ROW_CHK,
      OP_EDGE_RD,
      OP_COLOR_RD,
      OP_COLOR_CHK,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   accept;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic pre_fail;
      logic scan_done;
      logic uncolored;
      logic queue_empty;
      logic row_empty;
      logic conflict;
      logic edge_last;
   } stat_type;

endpackage

@@ design/bcb_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module bcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ design/bcb_ctrl.sv @@
// Controller state machine that sequences load, check, walk and clear.
module bcb_ctrl import bcb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     req_last,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_valid
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_IDLE;
      cmd.accept = 1'b0;
      busy       = 1'b1;
      rsp_valid  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
            if (start && req_last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.op   = OP_CHECK;
            state_in = stat.pre_fail ? S_RESULT : S_SCAN_RD;
         end
         S_SCAN_RD: begin
            cmd.op   = OP_SCAN_RD;
            state_in = stat.scan_done ? S_RESULT : S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cmd.op   = OP_SCAN_CHK;
            state_in = stat.uncolored ? S_POP : S_SCAN_RD;
         end
         S_POP: begin
            cmd.op   = OP_POP;
            state_in = stat.queue_empty ? S_SCAN_RD : S_ROW_RD;
         end
         S_ROW_RD: begin
            cmd.op   = OP_ROW_RD;
            state_in = S_ROW_CHK;
         end
         S_ROW_CHK: begin
            cmd.op   = OP_ROW_CHK;
            state_in = stat.row_empty ? S_POP : S_EDGE_RD;
         end
         S_EDGE_RD: begin
            cmd.op   = OP_EDGE_RD;
            state_in = S_COLOR_RD;
         end
         S_COLOR_RD: begin
            cmd.op   = OP_COLOR_RD;
            state_in = S_COLOR_CHK;
         end
         S_COLOR_CHK: begin
            cmd.op = OP_COLOR_CHK;
            if (stat.conflict) begin
               state_in = S_RESULT;
            end else if (stat.edge_last) begin
               state_in = S_POP;
            end else begin
               state_in = S_EDGE_RD;
            end
         end
         S_RESULT: begin
            cmd.op    = OP_RESULT;
            rsp_valid = 1'b1;
            state_in  = S_CLEAR;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

@@ design/bcb_dpath.sv @@
// Datapath: adjacency, color and queue memories with load and walk registers.
module bcb_dpath import bcb_pkg::*; #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  req_type                 req_data,
   input  logic                    csr_wr_en,
   input  logic [NODE_COUNT_W-1:0] csr_wr_data,
   output stat_type                stat,
   output rsp_type                 rsp_data
);

   localparam int NODE_AW = $clog2(MAX_NODES);
   localparam int EDGE_AW = $clog2(MAX_EDGES);
   localparam int NCW     = $clog2(MAX_NODES + 1);
   localparam int ECW     = $clog2(MAX_EDGES + 1);
   localparam int CMP_W   = (NCW > NODE_COUNT_W) ? NCW : NODE_COUNT_W;
   localparam int ROW_W   = 1 + 2 * ECW;
   localparam int QUE_W   = 1 + NODE_AW;

   logic [NODE_COUNT_W-1:0] node_count_ff, node_count_in;
   logic [ECW-1:0]          edge_count_ff, edge_count_in;
   logic                    have_src_ff, have_src_in;
   logic [NODE_FIELD_W-1:0] last_src_ff, last_src_in;
   logic [ECW-1:0]          cur_begin_ff, cur_begin_in;
   logic [NODE_FIELD_W-1:0] max_nbr_ff, max_nbr_in;
   logic [1:0]              err_ff, err_in;
   logic                    ok_ff, ok_in;
   logic [NODE_AW-1:0]      clr_ff, clr_in;
   logic [NCW-1:0]          scan_ff, scan_in;
   logic [NCW-1:0]          head_ff, head_in;
   logic [NCW-1:0]          tail_ff, tail_in;
   logic [NODE_AW-1:0]      u_ff, u_in;
   logic                    u_blue_ff, u_blue_in;
   logic [NODE_AW-1:0]      v_ff, v_in;
   logic [ECW-1:0]          eidx_ff, eidx_in;
   logic [ECW-1:0]          eend_ff, eend_in;

   // Memory ports
   logic               edge_we;
   logic [EDGE_AW-1:0] edge_waddr, edge_raddr;
   logic [NODE_AW-1:0] edge_wdata, edge_rdata;
   logic               row_we;
   logic [NODE_AW-1:0] row_waddr, row_raddr;
   logic [ROW_W-1:0]   row_wdata, row_rdata;
   logic               color_we;
   logic [NODE_AW-1:0] color_waddr, color_raddr;
   logic [1:0]         color_wdata, color_rdata;
   logic               que_we;
   logic [NODE_AW-1:0] que_waddr, que_raddr;
   logic [QUE_W-1:0]   que_wdata, que_rdata;

   // Derived values
   logic [CMP_W-1:0] n_nodes;
   logic [CMP_W-1:0] src_w, nbr_w;
   logic             range_bad;
   logic             row_valid;
   logic [ECW-1:0]   row_begin, row_end;
   logic [1:0]       cur_color;
   logic [ECW-1:0]   begin_sel;

   bcb_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_waddr), .wr_data(edge_wdata),
      .rd_addr(edge_raddr), .rd_data(edge_rdata)
   );

   bcb_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_row_ram (
      .clock(clock), .wr_en(row_we), .wr_addr(row_waddr), .wr_data(row_wdata),
      .rd_addr(row_raddr), .rd_data(row_rdata)
   );

   bcb_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_color_ram (
      .clock(clock), .wr_en(color_we), .wr_addr(color_waddr), .wr_data(color_wdata),
      .rd_addr(color_raddr), .rd_data(color_rdata)
   );

   bcb_ram #(.WIDTH(QUE_W), .DEPTH(MAX_NODES)) u_que_ram (
      .clock(clock), .wr_en(que_we), .wr_addr(que_waddr), .wr_data(que_wdata),
      .rd_addr(que_raddr), .rd_data(que_rdata)
   );

   // Saturate the node count and widen fields for compares
   always_comb begin
      n_nodes = (CMP_W'(node_count_ff) > CMP_W'(MAX_NODES)) ?
                CMP_W'(MAX_NODES) : CMP_W'(node_count_ff);
      src_w     = CMP_W'(req_data.source_node);
      nbr_w     = CMP_W'(req_data.neighbor_node);
      range_bad = (have_src_ff && (CMP_W'(last_src_ff) > n_nodes)) ||
                  ((edge_count_ff != '0) && (CMP_W'(max_nbr_ff) >= n_nodes));
      row_valid = row_rdata[ROW_W-1];
      row_begin = row_rdata[2*ECW-1:ECW];
      row_end   = row_rdata[ECW-1:0];
      cur_color = u_blue_ff ? COLOR_BLUE : COLOR_RED;
      begin_sel = (have_src_ff && (req_data.source_node == last_src_ff)) ?
                  cur_begin_ff : edge_count_ff;
   end

   // Status to the controller
   always_comb begin
      stat.clear_done  = (clr_ff == NODE_AW'(MAX_NODES - 1));
      stat.pre_fail    = (err_ff != ERR_NONE) || range_bad;
      stat.scan_done   = (CMP_W'(scan_ff) == n_nodes);
      stat.uncolored   = (color_rdata == COLOR_NONE);
      stat.queue_empty = (head_ff == tail_ff);
      stat.row_empty   = !row_valid || (row_begin >= row_end);
      stat.conflict    = (color_rdata == cur_color) && (v_ff != u_ff);
      stat.edge_last   = (ECW'(eidx_ff + 1'b1) == eend_ff);
      rsp_data.is_bipartite = ok_ff;
      rsp_data.error_code   = err_ff;
   end

   // Next register values and memory accesses
   always_comb begin
      node_count_in = node_count_ff;
      edge_count_in = edge_count_ff;
      have_src_in   = have_src_ff;
      last_src_in   = last_src_ff;
      cur_begin_in  = cur_begin_ff;
      max_nbr_in    = max_nbr_ff;
      err_in        = err_ff;
      ok_in         = ok_ff;
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      u_in          = u_ff;
      u_blue_in     = u_blue_ff;
      v_in          = v_ff;
      eidx_in       = eidx_ff;
      eend_in       = eend_ff;

      edge_we     = 1'b0;
      edge_waddr  = edge_count_ff[EDGE_AW-1:0];
      edge_wdata  = NODE_AW'(req_data.neighbor_node);
      edge_raddr  = eidx_ff[EDGE_AW-1:0];
      row_we      = 1'b0;
      row_waddr   = NODE_AW'(req_data.source_node);
      row_wdata   = {1'b1, begin_sel, ECW'(edge_count_ff + 1'b1)};
      row_raddr   = que_rdata[NODE_AW-1:0];
      color_we    = 1'b0;
      color_waddr = v_ff;
      color_wdata = u_blue_ff ? COLOR_RED : COLOR_BLUE;
      color_raddr = scan_ff[NODE_AW-1:0];
      que_we      = 1'b0;
      que_waddr   = tail_ff[NODE_AW-1:0];
      que_wdata   = {~u_blue_ff, v_ff};
      que_raddr   = head_ff[NODE_AW-1:0];

      if (csr_wr_en) begin
         node_count_in = csr_wr_data;
      end

      case (cmd.op)
         OP_CLEAR: begin
            // Invalidate one row and uncolor one node per cycle
            row_we      = 1'b1;
            row_waddr   = clr_ff;
            row_wdata   = '0;
            color_we    = 1'b1;
            color_waddr = clr_ff;
            color_wdata = COLOR_NONE;
            clr_in      = stat.clear_done ? '0 : NODE_AW'(clr_ff + 1'b1);
         end
         OP_IDLE: begin
            // Store an edge request, keeping the first error only
            if (cmd.accept && req_data.edge_valid && (err_ff == ERR_NONE)) begin
               if ((src_w >= n_nodes) || (nbr_w >= n_nodes)) begin
                  err_in = ERR_RANGE;
               end else if (have_src_ff && (req_data.source_node < last_src_ff)) begin
                  err_in = ERR_ORDER;
               end else if (edge_count_ff >= ECW'(MAX_EDGES)) begin
                  err_in = ERR_OVERFLOW;
               end else begin
                  edge_we       = 1'b1;
                  row_we        = 1'b1;
                  edge_count_in = ECW'(edge_count_ff + 1'b1);
                  have_src_in   = 1'b1;
                  last_src_in   = req_data.source_node;
                  cur_begin_in  = begin_sel;
                  if (req_data.neighbor_node > max_nbr_ff) begin
                     max_nbr_in = req_data.neighbor_node;
                  end
               end
            end
         end
         OP_CHECK: begin
            ok_in   = !stat.pre_fail;
            scan_in = '0;
            if ((err_ff == ERR_NONE) && range_bad) begin
               err_in = ERR_RANGE;
            end
         end
         OP_SCAN_RD: begin
            // Color read of the scan node is issued by default
         end
         OP_SCAN_CHK: begin
            // Start a walk from an uncolored node, else advance
            if (stat.uncolored) begin
               color_we    = 1'b1;
               color_waddr = scan_ff[NODE_AW-1:0];
               color_wdata = COLOR_BLUE;
               que_we      = 1'b1;
               que_waddr   = '0;
               que_wdata   = {1'b1, scan_ff[NODE_AW-1:0]};
               head_in     = '0;
               tail_in     = NCW'(1);
            end else begin
               scan_in = NCW'(scan_ff + 1'b1);
            end
         end
         OP_POP: begin
            // Queue read at head is issued by default
         end
         OP_ROW_RD: begin
            u_in      = que_rdata[NODE_AW-1:0];
            u_blue_in = que_rdata[QUE_W-1];
         end
         OP_ROW_CHK: begin
            eidx_in = row_begin;
            eend_in = row_end;
            if (stat.row_empty) begin
               head_in = NCW'(head_ff + 1'b1);
            end
         end
         OP_EDGE_RD: begin
            // Edge read at eidx is issued by default
         end
         OP_COLOR_RD: begin
            v_in        = edge_rdata;
            color_raddr = edge_rdata;
         end
         OP_COLOR_CHK: begin
            // Color a fresh neighbor and queue it, or flag a same-color edge
            if (stat.uncolored) begin
               color_we = 1'b1;
               if (tail_ff < NCW'(MAX_NODES)) begin
                  que_we  = 1'b1;
                  tail_in = NCW'(tail_ff + 1'b1);
               end
            end else if (stat.conflict) begin
               ok_in = 1'b0;
            end
            eidx_in = ECW'(eidx_ff + 1'b1);
            if (stat.edge_last) begin
               head_in = NCW'(head_ff + 1'b1);
            end
         end
         OP_RESULT: begin
            // Drop the loaded graph so the next request starts a new one
            edge_count_in = '0;
            have_src_in   = 1'b0;
            max_nbr_in    = '0;
            err_in        = ERR_NONE;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         edge_count_ff <= '0;
         have_src_ff   <= 1'b0;
         max_nbr_ff    <= '0;
         err_ff        <= ERR_NONE;
         clr_ff        <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
      end else begin
         node_count_ff <= node_count_in;
         edge_count_ff <= edge_count_in;
         have_src_ff   <= have_src_in;
         max_nbr_ff    <= max_nbr_in;
         err_ff        <= err_in;
         clr_ff        <= clr_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      last_src_ff  <= last_src_in;
      cur_begin_ff <= cur_begin_in;
      ok_ff        <= ok_in;
      scan_ff      <= scan_in;
      u_ff         <= u_in;
      u_blue_ff    <= u_blue_in;
      v_ff         <= v_in;
      eidx_ff      <= eidx_in;
      eend_ff      <= eend_in;
   end

endmodule

@@ design/bipartite_check_bfs.sv @@
// Top level of the bipartite check: breadth-first two-coloring of a loaded graph.
//
// Usage: edge requests arrive on req_data while start is high; a request is
// taken on a clock edge with start high and busy low. Requests group edges by
// source node in nondecreasing order; the request with last set closes the
// graph and starts the check. csr_wr_en/csr_wr_data write node_count; the
// user writes it only while the block is idle; the block does not enforce this.
// Throughput: one edge request per cycle while loading.
// After the last request: a check step; per node scanned, a scan read and
// check; per node taken from the walk queue, a pop, row read and row check;
// per edge walked, an edge read, color read and color check. Each step
// waits on one registered memory read. A failed load or an out-of-range count
// skips the walk. The result shows on rsp_data for one cycle with rsp_valid
// high; the receiver cannot stall it. Afterwards a sweep over all MAX_NODES
// entries clears the row and color memories while busy stays high.
// Reset: the same clearing sweep runs, node_count returns to 1024, and no
// request is taken until it ends.
module bipartite_check_bfs import bcb_pkg::*; #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   output rsp_type                 rsp_data,
   input  logic                    csr_wr_en,
   input  logic [NODE_COUNT_W-1:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   bcb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_data.last),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   bcb_dpath #(
      .MAX_NODES(MAX_NODES),
      .MAX_EDGES(MAX_EDGES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .stat       (stat),
      .rsp_data   (rsp_data)
   );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the bipartite check block.
`timescale 1ns / 100ps

module tb_top;
   import bcb_pkg::*;

   localparam int NODE_LIMIT = 1024;
   localparam int EDGE_LIMIT = 4096;
   localparam int STALL_LIMIT = 200000;
   localparam int NO_CFG = -1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [NODE_COUNT_W-1:0] csr_wr_data = '0;

   bipartite_check_bfs DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: compressed adjacency list and walk storage
   int node_cfg;
   int edge_mem [EDGE_LIMIT];
   int row_mem [NODE_LIMIT+1];
   int color_mem [NODE_LIMIT];
   int walk_q [NODE_LIMIT];
   int edge_cnt, rows_set, err_code;

   rsp_type verdict_q [$];
   int fail_cnt = 0;
   int stall_cnt = 0;
   bit gaps_on = 1'b1;

   function automatic int live_nodes();
      return (node_cfg > NODE_LIMIT) ? NODE_LIMIT : node_cfg;
   endfunction

   function automatic void flag_error(int code);
      if (err_code == 0) err_code = code;
   endfunction

   function automatic void fill_rows(int upto);
      while (rows_set <= upto && rows_set <= NODE_LIMIT) begin
         row_mem[rows_set] = edge_cnt;
         rows_set++;
      end
   endfunction

   // Two-color one component; return 0 on a same-color edge
   function automatic bit color_component(int root);
      int head, tail, u, v, e;
      color_mem[root] = COLOR_BLUE;
      head = 0;
      tail = 0;
      walk_q[tail++] = root;
      while (head < tail) begin
         u = walk_q[head];
         for (e = row_mem[u]; e < row_mem[u+1] && e < EDGE_LIMIT; e++) begin
            v = edge_mem[e];
            if (color_mem[v] == COLOR_NONE) begin
               color_mem[v] = (color_mem[u] == COLOR_BLUE) ? COLOR_RED : COLOR_BLUE;
               if (tail < NODE_LIMIT) walk_q[tail++] = v;
            end else if (color_mem[v] == color_mem[u] && v != u) begin
               return 1'b0;
            end
         end
         head++;
      end
      return 1'b1;
   endfunction

   function automatic bit two_colorable();
      int n, i;
      n = live_nodes();
      if (err_code != 0) return 1'b0;
      if (rows_set > n + 1) begin
         flag_error(ERR_RANGE);
         return 1'b0;
      end
      for (i = 0; i < edge_cnt; i++) begin
         if (edge_mem[i] >= n) begin
            flag_error(ERR_RANGE);
            return 1'b0;
         end
      end
      fill_rows(n);
      for (i = 0; i < NODE_LIMIT; i++) color_mem[i] = COLOR_NONE;
      for (i = 0; i < n; i++)
         if (color_mem[i] == COLOR_NONE && !color_component(i)) return 1'b0;
      return 1'b1;
   endfunction

   // Apply one accepted request; return 1 with the verdict when it closes a graph
   function automatic bit apply_request(req_type r, output rsp_type verdict);
      int n, src, nbr;
      n = live_nodes();
      src = r.source_node;
      nbr = r.neighbor_node;
      verdict = '0;
      if (r.edge_valid && err_code == 0) begin
         if (src >= n || nbr >= n) flag_error(ERR_RANGE);
         else if (rows_set > src + 1) flag_error(ERR_ORDER);
         else if (edge_cnt >= EDGE_LIMIT) flag_error(ERR_OVERFLOW);
         else begin
            fill_rows(src);
            edge_mem[edge_cnt] = nbr;
            edge_cnt++;
         end
      end
      if (!r.last) return 1'b0;
      verdict.is_bipartite = two_colorable();
      verdict.error_code = err_code[1:0];
      edge_cnt = 0;
      rows_set = 0;
      err_code = 0;
      return 1'b1;
   endfunction

   // Check each result against the oldest verdict; watch for stalls
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) stall_cnt <= 0;
         else stall_cnt <= stall_cnt + 1;
         if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
         if (rsp_valid) begin
            if (verdict_q.size() == 0) begin
               fail_cnt++;
               if (fail_cnt <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               if (rsp_data.is_bipartite !== verdict_q[0].is_bipartite ||
                   rsp_data.error_code !== verdict_q[0].error_code) begin
                  fail_cnt++;
                  if (fail_cnt <= 10)
                     $display("mismatch: expected bip=%0b err=%0d, got bip=%0b err=%0d",
                              verdict_q[0].is_bipartite, verdict_q[0].error_code,
                              rsp_data.is_bipartite, rsp_data.error_code);
               end
               void'(verdict_q.pop_front());
            end
         end
      end
   end

   // Present one request, hold it until taken, then queue its verdict if it closes a graph
   task automatic send_request(int src, int nbr, bit vld, bit lst,
                               bit typed = 1'b0, rsp_type typed_rsp = '0);
      req_type r;
      rsp_type verdict;
      r.source_node = src[9:0];
      r.neighbor_node = nbr[9:0];
      r.edge_valid = vld;
      r.last = lst;
      if (gaps_on && $urandom_range(7) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (apply_request(r, verdict)) verdict_q = {verdict_q, typed ? typed_rsp : verdict};
   endtask

   // Drain, let the clearing sweep finish, then write node_count
   task automatic write_node_count(int value);
      start <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[NODE_COUNT_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      node_cfg = value & 11'h7FF;
   endtask

   typedef struct {
      int cfg, src, nbr;
      bit vld, lst, typed, bip;
      logic [1:0] err;
   } stim_row;
   stim_row stim_tbl [$];

   function automatic void add_row(int cfg, int src, int nbr, bit vld, bit lst,
                                   bit typed = 1'b0, bit bip = 1'b0,
                                   logic [1:0] err = ERR_NONE);
      stim_row s;
      s = '{cfg, src, nbr, vld, lst, typed, bip, err};
      stim_tbl = {stim_tbl, s};
   endfunction

   // Random graph load: mostly well-formed, bipartite-leaning, with some noise
   task automatic random_graph(int cfg, int len, bit well_formed);
      int n, src, nbr, k, tries;
      bit vld, two_sided;
      bit side [NODE_LIMIT];
      write_node_count(cfg);
      n = live_nodes();
      two_sided = ($urandom_range(9) < 6);
      for (k = 0; k < NODE_LIMIT; k++) side[k] = $urandom_range(1);
      src = 0;
      for (k = 0; k < len; k++) begin
         vld = 1'b1;
         if (n > 0 && $urandom_range(2) == 0) src = src + $urandom_range(3);
         if (n > 0 && src >= n) src = n - 1;
         nbr = (n > 0) ? $urandom_range(n - 1) : 0;
         tries = 0;
         while (two_sided && n > 1 && side[nbr] == side[src] && tries < 6) begin
            nbr = $urandom_range(n - 1);
            tries++;
         end
         if (!well_formed || n == 0) begin
            case ($urandom_range(9))
               0, 1: vld = 1'b0;
               2: nbr = $urandom_range(1023);
               3: src = $urandom_range(1023);
               4: if (src > 0) src = src - 1 - $urandom_range(src - 1);
               default: ;
            endcase
         end else if ($urandom_range(19) == 0) begin
            vld = 1'b0;
         end
         send_request(src, nbr, vld, k == len - 1);
      end
   endtask

   initial begin
      int i, items, cfg, len;
      rsp_type typed_rsp;
      node_cfg = NODE_COUNT_RESET;
      edge_cnt = 0;
      rows_set = 0;
      err_code = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: empty graph, odd cycle, extremes, errors, register edges
      add_row(NO_CFG, 0, 0, 1'b0, 1'b1, 1'b1, 1'b1, ERR_NONE);
      add_row(NO_CFG, 0, 1, 1'b1, 1'b0);
      add_row(NO_CFG, 1, 2, 1'b1, 1'b0);
      add_row(NO_CFG, 2, 0, 1'b1, 1'b1, 1'b1, 1'b0, ERR_NONE);
      add_row(NO_CFG, 1023, 0, 1'b1, 1'b1);
      add_row(NO_CFG, 5, 5, 1'b1, 1'b1, 1'b1, 1'b1, ERR_NONE);
      add_row(4, 4, 0, 1'b1, 1'b1, 1'b1, 1'b0, ERR_RANGE);
      add_row(NO_CFG, 2, 1, 1'b1, 1'b0);
      add_row(NO_CFG, 1, 0, 1'b1, 1'b1, 1'b1, 1'b0, ERR_ORDER);
      add_row(0, 0, 0, 1'b0, 1'b1, 1'b1, 1'b1, ERR_NONE);
      add_row(NO_CFG, 0, 0, 1'b1, 1'b1, 1'b1, 1'b0, ERR_RANGE);
      add_row(2047, 1023, 1022, 1'b1, 1'b0);
      add_row(1000, 0, 0, 1'b0, 1'b1, 1'b1, 1'b0, ERR_RANGE);
      add_row(1, 0, 0, 1'b1, 1'b0);
      add_row(NO_CFG, 3, 0, 1'b1, 1'b0);
      add_row(NO_CFG, 0, 0, 1'b1, 1'b1, 1'b1, 1'b0, ERR_RANGE);
      add_row(3, 0, 1, 1'b1, 1'b0);
      add_row(NO_CFG, 0, 0, 1'b0, 1'b0);
      add_row(NO_CFG, 1, 2, 1'b1, 1'b0);
      add_row(NO_CFG, 2, 0, 1'b1, 1'b1);
      add_row(1024, 512, 511, 1'b1, 1'b0);
      add_row(NO_CFG, 682, 341, 1'b1, 1'b1);
      foreach (stim_tbl[j]) begin
         if (stim_tbl[j].cfg != NO_CFG) write_node_count(stim_tbl[j].cfg);
         typed_rsp.is_bipartite = stim_tbl[j].bip;
         typed_rsp.error_code = stim_tbl[j].err;
         send_request(stim_tbl[j].src, stim_tbl[j].nbr, stim_tbl[j].vld,
                      stim_tbl[j].lst, stim_tbl[j].typed, typed_rsp);
      end

      // Overflow: one full load plus an extra edge
      write_node_count(1024);
      for (i = 0; i <= EDGE_LIMIT; i++)
         send_request(i * 1023 / EDGE_LIMIT, $urandom_range(1023), 1'b1,
                      i == EDGE_LIMIT);

      // Random graphs; the last stretch runs without gaps
      items = 0;
      while (items < 2000) begin
         if (items > 1700) gaps_on = 1'b0;
         case ($urandom_range(19))
            0: cfg = 0;
            1: cfg = 1;
            2: cfg = 1024;
            3: cfg = $urandom_range(2047, 1025);
            4: cfg = $urandom_range(1023, 41);
            default: cfg = $urandom_range(40, 2);
         endcase
         len = $urandom_range(30, 1);
         random_graph(cfg, len, $urandom_range(4) != 0);
         items += len;
      end

      // Drain and let the block settle
      start <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (2 * NODE_LIMIT) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
